FILE: src/dift_pkg.sv
// shared types, constants and helpers for the doppler intensity transform
package dift_pkg;

  // reset value of the inverse light speed register, unsigned q0.32
  localparam logic [31:0] DefInvLightSpeed = 32'd42949673;

  // largest output intensity, q32.16
  localparam logic [47:0] OutMax = 48'hFFFF_FFFF_FFFF;

  // direction mode codes
  localparam logic ModeMul = 1'b0;
  localparam logic ModeDiv = 1'b1;

  // sideband carried along the coefficient divider
  typedef struct packed {
    logic        mode;
    logic [31:0] inten;
    logic        last;
    logic        inv;
    logic        clip;
  } div1_side_t;

  // sideband carried along the intensity divider
  typedef struct packed {
    logic        mode;
    logic        last;
    logic        inv;
    logic        sat0;
    logic        sat1;
    logic [47:0] res0;
  } div2_side_t;

  // magnitude of a signed 32 bit word, fits 32 bits unsigned
  function automatic logic [31:0] mag32(input logic [31:0] v);
    logic [31:0] m;
    m = v[31] ? (~v + 32'd1) : v;
    return m;
  endfunction

endpackage

FILE: src/dift_div_step.sv
// one registered step of a restoring divider with a sideband word
module dift_div_step #(
  parameter int unsigned RW = 64,
  parameter int unsigned QW = 64,
  parameter int unsigned SW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [RW-1:0] rem_i,
  input  logic [QW-1:0] quo_i,
  input  logic [RW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [RW-1:0] rem_o,
  output logic [QW-1:0] quo_o,
  output logic [RW-1:0] den_o,
  output logic [SW-1:0] side_o
);

  logic [RW:0]   shifted;
  logic [RW:0]   diff;
  logic          ge;
  logic [RW-1:0] rem_d;
  logic [QW-1:0] quo_d;
  logic          valid_q;
  logic [RW-1:0] rem_q;
  logic [QW-1:0] quo_q;
  logic [RW-1:0] den_q;
  logic [SW-1:0] side_q;

  // shift in the next numerator bit, trial subtract
  always_comb begin
    shifted = {rem_i, quo_i[QW-1]};
    diff    = shifted - {1'b0, den_i};
    ge      = (shifted >= {1'b0, den_i});
    rem_d   = ge ? diff[RW-1:0] : shifted[RW-1:0];
    quo_d   = {quo_i[QW-2:0], ge};
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    den_q  <= den_i;
    side_q <= side_i;
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign den_o   = den_q;
  assign side_o  = side_q;

endmodule

FILE: src/doppler_intensity_frame_transform.sv
// top level of the relativistic doppler transform of a specific intensity
//
// A word enters at any clock edge with start high; busy is always low,
// so one word can be taken in every cycle. The result word appears on
// intensity_out_o, speed_invalid_o, saturated_o and last_out_o for exactly
// one cycle with done_o high, in order. The pipeline is formed by the two
// pipelined dividers: 64 stages form the coefficient ratio and 48 stages
// form the comoving-to-lab quotient, plus four front stages for the velocity
// products, three for the coefficient square and the intensity products,
// and the output register.
// Throughput is one word per cycle with any number of words in flight.
// The receiver cannot stall; every result is shown once and then gone.
// cfg_we_i writes cfg_wdata_i into the inverse light speed register; write
// it only while no word is in flight.
// Reset clears all valid bits, dropping words in flight, and loads the
// default inverse light speed.
module doppler_intensity_frame_transform (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        start,
  output logic        busy,
  input  logic        mode_i,
  input  logic [31:0] vel_x_i,
  input  logic [31:0] vel_y_i,
  input  logic [31:0] vel_z_i,
  input  logic [31:0] dir_x_i,
  input  logic [31:0] dir_y_i,
  input  logic [31:0] dir_z_i,
  input  logic [31:0] intensity_in_i,
  input  logic        last_in_i,
  output logic        done_o,
  output logic [47:0] intensity_out_o,
  output logic        speed_invalid_o,
  output logic        saturated_o,
  output logic        last_out_o
);
  import dift_pkg::*;

  localparam int unsigned D1Steps = 64;
  localparam int unsigned D1Rw    = 63;
  localparam int unsigned D2Steps = 48;
  localparam int unsigned D2Rw    = 128;
  localparam int unsigned D1Sw    = $bits(div1_side_t);
  localparam int unsigned D2Sw    = $bits(div2_side_t);

  logic [31:0] inv_c_q;
  logic        accept;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_c_q <= DefInvLightSpeed;
    end else if (cfg_we_i) begin
      inv_c_q <= cfg_wdata_i;
    end
  end

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // stage 1: magnitudes and beta products
  logic [31:0] vel_w [3];
  logic [31:0] dir_w [3];
  logic        s1_valid_q;
  logic [63:0] s1_bprod_q [3];
  logic [2:0]  s1_sgn_q;
  logic [31:0] s1_dmag_q [3];
  logic        s1_mode_q, s1_last_q;
  logic [31:0] s1_inten_q;

  assign vel_w[0] = vel_x_i;
  assign vel_w[1] = vel_y_i;
  assign vel_w[2] = vel_z_i;
  assign dir_w[0] = dir_x_i;
  assign dir_w[1] = dir_y_i;
  assign dir_w[2] = dir_z_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      s1_bprod_q[i] <= {32'd0, mag32(vel_w[i])} * {32'd0, inv_c_q};
      s1_dmag_q[i]  <= mag32(dir_w[i]);
      s1_sgn_q[i]   <= vel_w[i][31] ^ dir_w[i][31];
    end
    s1_mode_q  <= mode_i;
    s1_last_q  <= last_in_i;
    s1_inten_q <= intensity_in_i;
  end

  // stage 2: beta squares and beta times cosine
  logic        s2_valid_q;
  logic [63:0] s2_sq_q [3];
  logic [63:0] s2_bd_q [3];
  logic [2:0]  s2_sgn_q;
  logic        s2_inv_q, s2_mode_q, s2_last_q;
  logic [31:0] s2_inten_q;
  logic        s2_inv_d;

  always_comb begin
    s2_inv_d = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (s1_bprod_q[i][63:48] != 16'd0) s2_inv_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      s2_sq_q[i] <= {32'd0, s1_bprod_q[i][47:16]} * {32'd0, s1_bprod_q[i][47:16]};
      s2_bd_q[i] <= {32'd0, s1_bprod_q[i][47:16]} * {32'd0, s1_dmag_q[i]};
    end
    s2_sgn_q   <= s1_sgn_q;
    s2_inv_q   <= s2_inv_d;
    s2_mode_q  <= s1_mode_q;
    s2_last_q  <= s1_last_q;
    s2_inten_q <= s1_inten_q;
  end

  // stage 3: beta squared sum, one minus beta dot n
  logic        s3_valid_q;
  logic [62:0] s3_den_q;
  logic [32:0] s3_wm_q;
  logic        s3_inv_q, s3_mode_q, s3_last_q;
  logic [31:0] s3_inten_q;
  logic [63:0] beta2;
  logic signed [35:0] dot_s;
  logic signed [35:0] w_s;
  logic signed [35:0] term_s;
  logic [35:0] wabs;

  always_comb begin
    beta2 = 64'd0;
    dot_s = 36'sd0;
    for (int i = 0; i < 3; i++) begin
      beta2  = beta2 + {2'b00, s2_sq_q[i][63:2]};
      term_s = $signed({4'd0, s2_bd_q[i][63:32]});
      dot_s  = s2_sgn_q[i] ? (dot_s - term_s) : (dot_s + term_s);
    end
    w_s  = $signed(36'd1 << 30) - dot_s;
    wabs = w_s[35] ? (~w_s + 36'd1) : w_s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_inv_q   <= s2_inv_q || (beta2[63:62] != 2'd0);
    s3_den_q   <= (63'd1 << 62) - {1'b0, beta2[61:0]};
    s3_wm_q    <= wabs[32:0];
    s3_mode_q  <= s2_mode_q;
    s3_last_q  <= s2_last_q;
    s3_inten_q <= s2_inten_q;
  end

  // stage 4: square of one minus beta dot n
  logic        s4_valid_q;
  logic [65:0] s4_w2_q;
  logic [62:0] s4_den_q;
  logic        s4_inv_q, s4_mode_q, s4_last_q;
  logic [31:0] s4_inten_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else begin
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_w2_q    <= {33'd0, s3_wm_q} * {33'd0, s3_wm_q};
    s4_den_q   <= s3_den_q;
    s4_inv_q   <= s3_inv_q;
    s4_mode_q  <= s3_mode_q;
    s4_last_q  <= s3_last_q;
    s4_inten_q <= s3_inten_q;
  end

  // coefficient ratio divider, clip when the quotient needs more than 64 bits
  div1_side_t d1_side0;
  logic              d1_valid [D1Steps+1];
  logic [D1Rw-1:0]   d1_rem   [D1Steps+1];
  logic [63:0]       d1_quo   [D1Steps+1];
  logic [D1Rw-1:0]   d1_den   [D1Steps+1];
  logic [D1Sw-1:0]   d1_side  [D1Steps+1];

  always_comb begin
    d1_side0.mode  = s4_mode_q;
    d1_side0.inten = s4_inten_q;
    d1_side0.last  = s4_last_q;
    d1_side0.inv   = s4_inv_q;
    d1_side0.clip  = ({27'd0, s4_w2_q[65:30]} >= s4_den_q);
  end

  assign d1_valid[0] = s4_valid_q;
  assign d1_rem[0]   = {27'd0, s4_w2_q[65:30]};
  assign d1_quo[0]   = {s4_w2_q[29:0], 34'd0};
  assign d1_den[0]   = s4_den_q;
  assign d1_side[0]  = d1_side0;

  for (genvar g = 0; g < D1Steps; g++) begin : g_div1
    dift_div_step #(.RW(D1Rw), .QW(64), .SW(D1Sw)) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (d1_valid[g]),
      .rem_i   (d1_rem[g]),
      .quo_i   (d1_quo[g]),
      .den_i   (d1_den[g]),
      .side_i  (d1_side[g]),
      .valid_o (d1_valid[g+1]),
      .rem_o   (d1_rem[g+1]),
      .quo_o   (d1_quo[g+1]),
      .den_o   (d1_den[g+1]),
      .side_o  (d1_side[g+1])
    );
  end

  // k1: ratio partial products for its square
  div1_side_t  d1_out;
  logic [63:0] ratio;
  logic        k1_valid_q;
  logic [63:0] k1_ll_q, k1_lh_q, k1_hh_q;
  logic        k1_inv_q, k1_clip_q, k1_mode_q, k1_last_q;
  logic [31:0] k1_inten_q;

  assign d1_out = div1_side_t'(d1_side[D1Steps]);
  assign ratio  = d1_out.clip ? 64'hFFFF_FFFF_FFFF_FFFF : d1_quo[D1Steps];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k1_valid_q <= 1'b0;
    end else begin
      k1_valid_q <= d1_valid[D1Steps];
    end
  end

  always_ff @(posedge clk_i) begin
    k1_ll_q    <= {32'd0, ratio[31:0]} * {32'd0, ratio[31:0]};
    k1_lh_q    <= {32'd0, ratio[31:0]} * {32'd0, ratio[63:32]};
    k1_hh_q    <= {32'd0, ratio[63:32]} * {32'd0, ratio[63:32]};
    k1_inv_q   <= d1_out.inv || (ratio == 64'd0);
    k1_clip_q  <= d1_out.clip;
    k1_mode_q  <= d1_out.mode;
    k1_last_q  <= d1_out.last;
    k1_inten_q <= d1_out.inten;
  end

  // k2: coefficient as the square of the ratio
  logic         k2_valid_q;
  logic [127:0] k2_k_q;
  logic         k2_inv_q, k2_clip_q, k2_mode_q, k2_last_q;
  logic [31:0]  k2_inten_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k2_valid_q <= 1'b0;
    end else begin
      k2_valid_q <= k1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    k2_k_q     <= {k1_hh_q, 64'd0} + {31'd0, k1_lh_q, 33'd0} + {64'd0, k1_ll_q};
    k2_inv_q   <= k1_inv_q;
    k2_clip_q  <= k1_clip_q;
    k2_mode_q  <= k1_mode_q;
    k2_last_q  <= k1_last_q;
    k2_inten_q <= k1_inten_q;
  end

  // k3: intensity times coefficient limbs, divide-mode overflow test
  logic         k3_valid_q;
  logic [63:0]  k3_p_q [4];
  logic [127:0] k3_k_q;
  logic         k3_sat1_q, k3_inv_q, k3_clip_q, k3_mode_q, k3_last_q;
  logic [31:0]  k3_inten_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k3_valid_q <= 1'b0;
    end else begin
      k3_valid_q <= k2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 4; j++) begin
      k3_p_q[j] <= {32'd0, k2_inten_q} * {32'd0, k2_k_q[32*j +: 32]};
    end
    k3_sat1_q  <= ({80'd0, k2_inten_q, 16'd0} >= k2_k_q);
    k3_k_q     <= k2_k_q;
    k3_inv_q   <= k2_inv_q;
    k3_clip_q  <= k2_clip_q;
    k3_mode_q  <= k2_mode_q;
    k3_last_q  <= k2_last_q;
    k3_inten_q <= k2_inten_q;
  end

  // multiply-mode result, then the intensity divider
  logic [159:0] prod;
  div2_side_t   d2_side0;
  logic              d2_valid [D2Steps+1];
  logic [D2Rw-1:0]   d2_rem   [D2Steps+1];
  logic [47:0]       d2_quo   [D2Steps+1];
  logic [D2Rw-1:0]   d2_den   [D2Steps+1];
  logic [D2Sw-1:0]   d2_side  [D2Steps+1];

  always_comb begin
    prod = {96'd0, k3_p_q[0]} + {64'd0, k3_p_q[1], 32'd0}
         + {32'd0, k3_p_q[2], 64'd0} + {k3_p_q[3], 96'd0};
    d2_side0.mode = k3_mode_q;
    d2_side0.last = k3_last_q;
    d2_side0.inv  = k3_inv_q;
    d2_side0.sat0 = (prod[159:112] != 48'd0) || (k3_clip_q && (k3_inten_q != 32'd0));
    d2_side0.sat1 = k3_sat1_q;
    d2_side0.res0 = prod[111:64];
  end

  assign d2_valid[0] = k3_valid_q;
  assign d2_rem[0]   = {80'd0, k3_inten_q, 16'd0};
  assign d2_quo[0]   = 48'd0;
  assign d2_den[0]   = k3_k_q;
  assign d2_side[0]  = d2_side0;

  for (genvar g = 0; g < D2Steps; g++) begin : g_div2
    dift_div_step #(.RW(D2Rw), .QW(48), .SW(D2Sw)) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (d2_valid[g]),
      .rem_i   (d2_rem[g]),
      .quo_i   (d2_quo[g]),
      .den_i   (d2_den[g]),
      .side_i  (d2_side[g]),
      .valid_o (d2_valid[g+1]),
      .rem_o   (d2_rem[g+1]),
      .quo_o   (d2_quo[g+1]),
      .den_o   (d2_den[g+1]),
      .side_o  (d2_side[g+1])
    );
  end

  // output word
  div2_side_t  d2_out;
  logic        sat_sel;
  logic [47:0] res_d;
  logic        done_q, inv_q, sat_q, last_q;
  logic [47:0] res_q;

  assign d2_out = div2_side_t'(d2_side[D2Steps]);

  always_comb begin
    sat_sel = (d2_out.mode == ModeDiv) ? d2_out.sat1 : d2_out.sat0;
    if (d2_out.inv) begin
      res_d   = 48'd0;
      sat_sel = 1'b0;
    end else if (sat_sel) begin
      res_d = OutMax;
    end else if (d2_out.mode == ModeDiv) begin
      res_d = d2_quo[D2Steps];
    end else begin
      res_d = d2_out.res0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= d2_valid[D2Steps];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    inv_q  <= d2_out.inv;
    sat_q  <= sat_sel;
    last_q <= d2_out.last;
  end

  assign done_o          = done_q;
  assign intensity_out_o = res_q;
  assign speed_invalid_o = inv_q;
  assign saturated_o     = sat_q;
  assign last_out_o      = last_q;

endmodule

FILE: bench/testbench.sv
// self-checking bench for the doppler intensity transform, random and directed words
module testbench;
  import dift_pkg::*;

  typedef struct {
    logic        mode;
    logic [31:0] vel_x, vel_y, vel_z;
    logic [31:0] dir_x, dir_y, dir_z;
    logic [31:0] inten;
    logic        last;
  } word_t;

  typedef struct {
    logic [47:0] inten;
    logic        invalid;
    logic        sat;
    logic        last;
  } result_t;

  localparam int LatencyCycles = 120;
  localparam int CycleLimit    = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        start = 1'b0;
  logic        busy;
  logic        mode_i = 1'b0;
  logic [31:0] vel_x_i = '0, vel_y_i = '0, vel_z_i = '0;
  logic [31:0] dir_x_i = '0, dir_y_i = '0, dir_z_i = '0;
  logic [31:0] intensity_in_i = '0;
  logic        last_in_i = 1'b0;
  logic        done_o;
  logic [47:0] intensity_out_o;
  logic        speed_invalid_o, saturated_o, last_out_o;

  word_t       pending_words[$];
  result_t     expected_results[$];
  word_t       drive_word;
  logic [31:0] inv_c = DefInvLightSpeed;
  int          idle_left = 0;
  bit          quiet = 0;
  int          errors = 0;
  int          words_sent = 0;
  int          results_seen = 0;
  int          invalid_seen = 0;
  int          sat_seen = 0;
  int          cycles = 0;

  doppler_intensity_frame_transform u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .start(start), .busy(busy), .mode_i(mode_i),
    .vel_x_i(vel_x_i), .vel_y_i(vel_y_i), .vel_z_i(vel_z_i),
    .dir_x_i(dir_x_i), .dir_y_i(dir_y_i), .dir_z_i(dir_z_i),
    .intensity_in_i(intensity_in_i), .last_in_i(last_in_i),
    .done_o(done_o), .intensity_out_o(intensity_out_o),
    .speed_invalid_o(speed_invalid_o), .saturated_o(saturated_o), .last_out_o(last_out_o)
  );

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // expected transformed intensity of one word under a given 1/c
  function automatic result_t doppler_predict(word_t wd, logic [31:0] ic);
    logic [31:0]        vv[3];
    logic [31:0]        dd[3];
    logic [31:0]        vm, dm;
    logic [63:0]        bmag[3];
    logic               bneg[3];
    logic [63:0]        beta2, d, wm, r, term;
    logic signed [63:0] s, w;
    logic [127:0]       num, rq, k, q;
    logic [159:0]       p;
    logic               inv, sat, clip;
    result_t            res;
    vv = '{wd.vel_x, wd.vel_y, wd.vel_z};
    dd = '{wd.dir_x, wd.dir_y, wd.dir_z};
    inv = 1'b0;
    sat = 1'b0;
    s = '0;
    beta2 = '0;
    q = '0;
    // per-axis speed over c
    for (int i = 0; i < 3; i++) begin
      vm = vv[i][31] ? -vv[i] : vv[i];
      bneg[i] = vv[i][31];
      bmag[i] = ({32'd0, vm} * {32'd0, ic}) >> 16;
      if (bmag[i] >= 64'h1_0000_0000) inv = 1'b1;
    end
    if (!inv) begin
      for (int i = 0; i < 3; i++) beta2 += (bmag[i] * bmag[i]) >> 2;
      if (beta2 >= (64'd1 << 62)) inv = 1'b1;
    end
    if (!inv) begin
      // beta dot n, then ratio (1 - beta.n)^2 / (1 - beta^2)
      for (int i = 0; i < 3; i++) begin
        dm = dd[i][31] ? -dd[i] : dd[i];
        term = (bmag[i] * {32'd0, dm}) >> 32;
        s = (bneg[i] != dd[i][31]) ? s - $signed(term) : s + $signed(term);
      end
      w = (64'sd1 <<< 30) - s;
      wm = w[63] ? -w : w;
      num = ({64'd0, wm} * {64'd0, wm}) << 34;
      d = (64'd1 << 62) - beta2;
      rq = num / {64'd0, d};
      clip = |rq[127:64];
      r = clip ? '1 : rq[63:0];
      if (r == 0) inv = 1'b1;
      if (!inv) begin
        k = {64'd0, r} * {64'd0, r};
        if (wd.mode == ModeMul) begin
          p = {128'd0, wd.inten} * {32'd0, k};
          q = {32'd0, p[159:64]};
          if (clip && wd.inten != 0) sat = 1'b1;
        end else begin
          q = {32'd0, wd.inten, 64'd0} / k;
        end
        if (|q[127:48]) sat = 1'b1;
      end
    end
    res.invalid = inv;
    res.sat = inv ? 1'b0 : sat;
    res.inten = inv ? 48'd0 : (sat ? OutMax : q[47:0]);
    res.last = wd.last;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got, input logic [63:0] exp);
    errors++;
    $display("mismatch on result %0d: %s got %0h expected %0h", results_seen, what, got, exp);
  endtask

  // driver: one word per accepted start, random idle bursts
  always @(posedge clk_i) begin
    if (start && !busy) begin
      expected_results.push_back(doppler_predict(drive_word, inv_c));
      words_sent++;
    end
    if (idle_left > 0) begin
      idle_left <= idle_left - 1;
      start <= 1'b0;
    end else if (pending_words.size() > 0) begin
      drive_word = pending_words.pop_front();
      mode_i <= drive_word.mode;
      vel_x_i <= drive_word.vel_x;
      vel_y_i <= drive_word.vel_y;
      vel_z_i <= drive_word.vel_z;
      dir_x_i <= drive_word.dir_x;
      dir_y_i <= drive_word.dir_y;
      dir_z_i <= drive_word.dir_z;
      intensity_in_i <= drive_word.inten;
      last_in_i <= drive_word.last;
      start <= 1'b1;
      if (!quiet && $urandom_range(0, 5) == 0) idle_left <= $urandom_range(1, 7);
    end else begin
      start <= 1'b0;
    end
  end

  // monitor: compare each strobed result word with the oldest expectation
  always @(posedge clk_i) begin
    result_t e;
    if (done_o) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected word", intensity_out_o, 0);
      end else begin
        e = expected_results.pop_front();
        if (intensity_out_o !== e.inten) report_mismatch("intensity", intensity_out_o, e.inten);
        if (speed_invalid_o !== e.invalid)
          report_mismatch("speed_invalid", speed_invalid_o, e.invalid);
        if (saturated_o !== e.sat) report_mismatch("saturated", saturated_o, e.sat);
        if (last_out_o !== e.last) report_mismatch("last", last_out_o, e.last);
        if (e.invalid) invalid_seen++;
        if (e.sat) sat_seen++;
      end
      results_seen++;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic add_word(input logic m, input logic [31:0] vx, vy, vz, dx, dy, dz,
                          input logic [31:0] it, input logic lst);
    word_t wd;
    wd = '{m, vx, vy, vz, dx, dy, dz, it, lst};
    pending_words.push_back(wd);
  endtask

  // velocity component scaled so most words stay below light speed
  function automatic logic [31:0] rand_vel(input logic [31:0] ic);
    logic [63:0] lim;
    logic [31:0] m;
    if ($urandom_range(0, 9) == 0) return $urandom;
    lim = (ic == 0) ? 64'h7FFF_FFFF : ((64'd1 << 48) / {32'd0, ic}) * 55 / 100;
    if (lim > 64'h7FFF_FFFF) lim = 64'h7FFF_FFFF;
    m = $urandom_range(0, lim[31:0]);
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  function automatic logic [31:0] rand_dir();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
  endfunction

  task automatic add_random(input int n);
    logic [31:0] it;
    for (int i = 0; i < n; i++) begin
      it = $urandom_range(0, 3) == 0 ? $urandom_range(0, 32'h0003_0000) : $urandom;
      add_word($urandom_range(0, 1), rand_vel(inv_c), rand_vel(inv_c), rand_vel(inv_c),
               rand_dir(), rand_dir(), rand_dir(), it, $urandom_range(0, 1));
    end
  endtask

  // wait for the pipeline to drain, then write 1/c
  task automatic set_inv_c(input logic [31:0] val);
    wait (pending_words.size() == 0 && expected_results.size() == 0 && !start);
    repeat (LatencyCycles + 10) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    inv_c = val;
  endtask

  // stimulus sequence
  initial begin
    logic [31:0] phase_c[6];
    phase_c = '{32'd0, 32'hFFFF_FFFF, 32'h8000_0000, $urandom, $urandom, DefInvLightSpeed};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words at reset value of 1/c
    add_word(ModeMul, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 1);
    add_word(ModeDiv, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 0);
    add_word(ModeMul, 32'h0064_0000, 0, 0, 32'h4000_0000, 0, 0, 32'h0001_0000, 1);
    add_word(ModeDiv, 32'h0064_0000, 0, 0, 32'h4000_0000, 0, 0, 32'h0001_0000, 0);
    add_word(ModeMul, 32'h8000_0000, 0, 0, 32'hC000_0000, 0, 0, 32'h0001_0000, 0);
    add_word(ModeMul, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0, 32'hFFFF_FFFF, 1);
    add_word(ModeMul, 32'h0063_0000, 0, 0, 32'hC000_0000, 0, 0, 32'hFFFF_FFFF, 0);
    add_word(ModeDiv, 32'hFF9D_0000, 0, 0, 32'h4000_0000, 0, 0, 32'hFFFF_FFFF, 1);
    add_word(ModeMul, 32'h0030_0000, 32'hFFD0_0000, 32'h0030_0000,
             32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 0);
    add_word(ModeDiv, 32'h0030_0000, 32'h0030_0000, 32'hFFD0_0000,
             32'h4000_0000, 32'h4000_0000, 32'h4000_0000, 0, 1);
    add_random(150);

    for (int ph = 0; ph < 6; ph++) begin
      set_inv_c(phase_c[ph]);
      if (phase_c[ph] == 32'hFFFF_FFFF) begin
        // speed just below c against the ray clips the coefficient; one more lsb is invalid
        add_word(ModeMul, 32'h0001_0000, 0, 0, 32'h8000_0000, 0, 0, 32'h0001_0000, 1);
        add_word(ModeMul, 32'h0001_0000, 0, 0, 32'h8000_0000, 0, 0, 0, 0);
        add_word(ModeDiv, 32'h0001_0000, 0, 0, 32'h8000_0000, 0, 0, 32'hFFFF_FFFF, 1);
        add_word(ModeMul, 32'h0001_0001, 0, 0, 0, 0, 0, 32'h0001_0000, 0);
      end
      if (phase_c[ph] == 32'h8000_0000) begin
        // beta.n of exactly one gives a zero coefficient
        add_word(ModeMul, 32'hFFFF_0000, 0, 0, 32'h8000_0000, 0, 0, 32'h0001_0000, 1);
        add_word(ModeDiv, 32'hFFFF_0000, 0, 0, 32'h8000_0000, 0, 0, 32'h0001_0000, 0);
      end
      if (ph == 5) quiet = 1;
      add_random(150);
    end

    wait (pending_words.size() == 0 && expected_results.size() == 0 && !start);
    repeat (LatencyCycles + 10) @(posedge clk_i);
    $display("%0d words sent, %0d results checked (%0d invalid, %0d saturated)",
             words_sent, results_seen, invalid_seen, sat_seen);
    $display("seven settings of 1/c including zero and full scale, both modes");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/dift_pkg.sv
src/dift_div_step.sv
src/doppler_intensity_frame_transform.sv
bench/testbench.sv
